// ===== hdl/lnab_pkg.sv =====
// ----------------------------------------------------------------------------
// lnab_pkg
// Shared types and constants for the length-prefixed to start-code converter.
// ----------------------------------------------------------------------------
package lnab_pkg;

   // one input byte of the access unit
   typedef struct packed {
      logic [7:0] in_byte;
      logic       in_last;
   } req_type;

   // one output result
   typedef struct packed {
      logic [7:0] out_byte;
      logic       run_last;
      logic       unit_end;
      logic [1:0] status;
   } rsp_type;

   // result status codes
   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_ZERO  = 2'd1;
   localparam logic [1:0] ST_TRUNC = 2'd2;

   // parser phase
   typedef enum logic [1:0] {
      PH_PREFIX  = 2'd0,
      PH_PAYLOAD = 2'd1,
      PH_DROP    = 2'd2
   } phase_type;

   // work handed from the front to the back
   typedef enum logic [1:0] {
      CMD_START = 2'd0,
      CMD_DATA  = 2'd1,
      CMD_ERROR = 2'd2
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type kind;
      logic [7:0]   data;
      logic         unit_end;
      logic [1:0]   status;
   } cmd_type;

   // command queue, deep enough to hold a start code and the payload
   // bytes that arrive while it is sent
   localparam int QUEUE_DEPTH = 8;
   localparam int QUEUE_AW    = 3;

   // start code is sent as four bytes, the last one carries this value
   localparam int         START_BEATS = 4;
   localparam logic [7:0] START_TAIL  = 8'h01;

endpackage

// ===== hdl/lnab_front.sv =====
// ----------------------------------------------------------------------------
// lnab_front
// Parses the length prefix and payload of each unit, one byte per cycle when
// the queue has room; each byte gives at most one command for the back end.
// ----------------------------------------------------------------------------
module lnab_front #(
   parameter int PREFIX_BYTES = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   input  lnab_pkg::req_type in_req,
   input  logic             q_full,
   output logic             in_stall,
   output logic             push,
   output lnab_pkg::cmd_type push_cmd
);
   import lnab_pkg::*;

   localparam int LEN_W = 8 * PREFIX_BYTES;
   localparam int CNT_W = (PREFIX_BYTES > 1) ? $clog2(PREFIX_BYTES) : 1;

   phase_type          phase_ff,        phase_in;
   logic [CNT_W-1:0]   prefix_count_ff, prefix_count_in;
   logic [LEN_W-1:0]   length_accum_ff, length_accum_in;
   logic [LEN_W-1:0]   payload_left_ff, payload_left_in;

   logic               accept;
   logic [LEN_W-1:0]   acc_next;
   logic               prefix_done;

   assign in_stall    = q_full;
   assign accept      = in_valid && !q_full;
   assign acc_next    = (length_accum_ff << 8) | LEN_W'(in_req.in_byte);
   assign prefix_done = (prefix_count_ff == CNT_W'(PREFIX_BYTES - 1));

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= PH_PREFIX;
         prefix_count_ff <= '0;
         length_accum_ff <= '0;
         payload_left_ff <= '0;
      end else begin
         phase_ff        <= phase_in;
         prefix_count_ff <= prefix_count_in;
         length_accum_ff <= length_accum_in;
         payload_left_ff <= payload_left_in;
      end
   end

   always_comb begin
      phase_in          = phase_ff;
      prefix_count_in   = prefix_count_ff;
      length_accum_in   = length_accum_ff;
      payload_left_in   = payload_left_ff;
      push              = 1'b0;
      push_cmd.kind     = CMD_ERROR;
      push_cmd.data     = 8'd0;
      push_cmd.unit_end = 1'b0;
      push_cmd.status   = ST_OK;

      if (accept) begin
         unique case (phase_ff)
            PH_PREFIX: begin
               if (!prefix_done) begin
                  if (in_req.in_last) begin
                     push            = 1'b1;
                     push_cmd.status = ST_TRUNC;
                     prefix_count_in = '0;
                     length_accum_in = '0;
                  end else begin
                     prefix_count_in = prefix_count_ff + 1'b1;
                     length_accum_in = acc_next;
                  end
               end else begin
                  prefix_count_in = '0;
                  length_accum_in = '0;
                  push            = 1'b1;
                  if (acc_next == '0) begin
                     push_cmd.status = ST_ZERO;
                     phase_in        = in_req.in_last ? PH_PREFIX : PH_DROP;
                  end else if (in_req.in_last) begin
                     push_cmd.status = ST_TRUNC;
                  end else begin
                     push_cmd.kind   = CMD_START;
                     payload_left_in = acc_next;
                     phase_in        = PH_PAYLOAD;
                  end
               end
            end
            PH_PAYLOAD: begin
               push = 1'b1;
               if (payload_left_ff > LEN_W'(1)) begin
                  if (in_req.in_last) begin
                     // unit cut short by the end of the access unit
                     push_cmd.status = ST_TRUNC;
                     payload_left_in = '0;
                     phase_in        = PH_PREFIX;
                  end else begin
                     push_cmd.kind   = CMD_DATA;
                     push_cmd.data   = in_req.in_byte;
                     payload_left_in = payload_left_ff - LEN_W'(1);
                  end
               end else begin
                  push_cmd.kind     = CMD_DATA;
                  push_cmd.data     = in_req.in_byte;
                  push_cmd.unit_end = in_req.in_last;
                  payload_left_in   = '0;
                  phase_in          = PH_PREFIX;
               end
            end
            default: begin
               if (in_req.in_last) begin
                  phase_in = PH_PREFIX;
               end
            end
         endcase
      end
   end

endmodule

// ===== hdl/lnab_queue.sv =====
// ----------------------------------------------------------------------------
// lnab_queue
// Small command queue between the parser and the output sequencer.
// ----------------------------------------------------------------------------
module lnab_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  lnab_pkg::cmd_type push_cmd,
   input  logic              pop,
   output logic              head_valid,
   output lnab_pkg::cmd_type head_cmd,
   output logic              full
);
   import lnab_pkg::*;

   cmd_type                entry_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_AW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_AW:0]      count_ff,  count_in;
   logic                   do_pop;

   assign head_valid = (count_ff != '0);
   assign full       = (count_ff == (QUEUE_AW + 1)'(QUEUE_DEPTH));
   assign head_cmd   = entry_ff[rd_ptr_ff];
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = push   ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push && do_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

// ===== hdl/lnab_back.sv =====
// ----------------------------------------------------------------------------
// lnab_back
// Expands queued commands into output results and holds them in the
// output register until the receiver takes them.
// ----------------------------------------------------------------------------
module lnab_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              head_valid,
   input  lnab_pkg::cmd_type head_cmd,
   output logic              pop,
   output logic              out_valid,
   input  logic              out_stall,
   output lnab_pkg::rsp_type out_rsp
);
   import lnab_pkg::*;

   localparam int BEAT_W = $clog2(START_BEATS);

   logic [BEAT_W-1:0] beat_ff, beat_in;
   logic              valid_ff, valid_in;
   rsp_type           rsp_ff, rsp_in;
   logic              load;
   logic              last_beat;

   assign load      = head_valid && (!valid_ff || !out_stall);
   assign last_beat = (beat_ff == BEAT_W'(START_BEATS - 1));

   always_comb begin
      beat_in         = beat_ff;
      valid_in        = valid_ff && out_stall;
      rsp_in          = rsp_ff;
      pop             = 1'b0;
      if (load) begin
         valid_in        = 1'b1;
         rsp_in.out_byte = 8'd0;
         rsp_in.run_last = 1'b1;
         rsp_in.unit_end = 1'b0;
         rsp_in.status   = ST_OK;
         unique case (head_cmd.kind)
            CMD_START: begin
               // start code: zero bytes then the tail byte
               rsp_in.out_byte = last_beat ? START_TAIL : 8'd0;
               rsp_in.run_last = last_beat;
               pop             = last_beat;
               beat_in         = last_beat ? '0 : beat_ff + 1'b1;
            end
            CMD_DATA: begin
               rsp_in.out_byte = head_cmd.data;
               rsp_in.unit_end = head_cmd.unit_end;
               pop             = 1'b1;
            end
            default: begin
               rsp_in.status = head_cmd.status;
               pop           = 1'b1;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         beat_ff  <= '0;
         valid_ff <= 1'b0;
      end else begin
         beat_ff  <= beat_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign out_valid = valid_ff;
   assign out_rsp   = rsp_ff;

endmodule

// ===== hdl/length_prefixed_nal_to_annexb_unit.sv =====
// ----------------------------------------------------------------------------
// length_prefixed_nal_to_annexb_unit
// Converts length-prefixed video units to start-code delimited form.
// ----------------------------------------------------------------------------
// Input channel (req_): one byte of the access unit per request, with a flag
// on its final byte. Each unit is a big-endian length of PREFIX_BYTES bytes
// and that many payload bytes.
// Output channel (rsp_): the start code 00 00 00 01 goes out as four results
// when the last prefix byte arrives, then each payload byte as one result.
// A zero length or a unit cut short by the end of the access unit gives one
// error result; bytes are then dropped up to the flagged last byte.
// Throughput: one request per cycle while req_stall is low. A prefix byte
// gives a command only when it ends the prefix or the access unit; the queue
// holds the payload bytes that follow a start code while its four bytes go
// out. The output sequencer sends one result per cycle while rsp_stall is low.
// With the queue empty, a result passes the queue and the output register on
// its way to rsp_valid; payload bytes right behind a start code wait for it.
// An eight-entry command queue sits between parser and output register, so
// req_stall rises only when the queue is full; with rsp_stall held high the
// output register and queue fill and then the input stalls.
// Reset: synchronous, clears the parser to the start of a prefix and empties
// the queue and output register.
// ----------------------------------------------------------------------------
module length_prefixed_nal_to_annexb_unit #(
   parameter int PREFIX_BYTES = 4
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  lnab_pkg::req_type req_payload,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output lnab_pkg::rsp_type rsp_payload
);
   import lnab_pkg::*;

   logic    q_full;
   logic    push;
   cmd_type push_cmd;
   logic    pop;
   logic    head_valid;
   cmd_type head_cmd;

   lnab_front #(
      .PREFIX_BYTES (PREFIX_BYTES)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req_valid),
      .in_req   (req_payload),
      .q_full   (q_full),
      .in_stall (req_stall),
      .push     (push),
      .push_cmd (push_cmd)
   );

   lnab_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_cmd   (push_cmd),
      .pop        (pop),
      .head_valid (head_valid),
      .head_cmd   (head_cmd),
      .full       (q_full)
   );

   lnab_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_cmd   (head_cmd),
      .pop        (pop),
      .out_valid  (rsp_valid),
      .out_stall  (rsp_stall),
      .out_rsp    (rsp_payload)
   );

endmodule
